/* hdl/rrs_pkg.sv */
// shared types and constants for the round-robin time-slice scheduler
// no dependencies
package rrs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    localparam logic [15:0] QUANTUM_RESET = 16'd3;
    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    localparam logic [2:0] ST_RUN = 3'd0;
    localparam logic [2:0] ST_ADDED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;

    localparam int PADDR_W = 3;
    localparam logic REG_QUANTUM = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [7:0]  process_id;
        logic [15:0] burst_length;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slice_owner;
        logic [15:0] slice_length;
        logic        finished;
        logic [31:0] finish_time;
        logic [15:0] total_run;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] remaining;
        logic [15:0] run;
    } entry_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_FULL,
        OP_ZERO,
        OP_RUN,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic kind;
        logic burst_zero;
        logic full;
        logic empty;
    } dp_status_t;

endpackage

/* hdl/rrs_ctrl.sv */
// controller state machine: takes an item, then picks the operation for it
// depends on rrs_pkg
module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    assign busy = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg;
        cmd.load = 1'b0;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                    busy_next = 1'b1;
                end
            end
            S_EXEC:
            begin
                if (dp_status.kind == KIND_ADD)
                begin
                    if (dp_status.burst_zero)
                        cmd.op = OP_ZERO;
                    else if (dp_status.full)
                        cmd.op = OP_FULL;
                    else
                        cmd.op = OP_ADD;
                end
                else
                begin
                    if (dp_status.empty)
                        cmd.op = OP_EMPTY;
                    else
                        cmd.op = OP_RUN;
                end
                state_next = S_IDLE;
                busy_next = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
        end
    end

    // the execute state always returns to idle
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg)
        else $error("execute phase longer than one cycle");

    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg == S_EXEC))
        else $error("busy out of step with state");

    a_load_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.op != OP_NONE))
        else $error("loaded beat not executed");

endmodule

/* hdl/rrs_datapath.sv */
// datapath: ready queue memory, pointers, count, elapsed clock and result register
// depends on rrs_pkg
module rrs_datapath
    import rrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  dp_status,
    input  in_beat_t    item,
    input  logic [15:0] time_quantum,
    output logic        done,
    output out_beat_t   result
);

    entry_t             queue_mem [QUEUE_DEPTH];
    in_beat_t           item_reg;
    entry_t             rd_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [IDX_W-1:0]   tail_reg;
    logic [IDX_W-1:0]   tail_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [31:0]        elapsed_reg;
    logic [31:0]        elapsed_next;
    logic               done_reg;
    out_beat_t          result_reg;
    out_beat_t          result_next;

    logic               wr_en;
    entry_t             wr_data;
    logic [15:0]        slice_len;
    logic [15:0]        rem_new;
    logic [15:0]        run_new;
    logic [32:0]        clock_sum;
    logic [31:0]        clock_new;
    logic               slice_done;

    assign dp_status.kind = item_reg.kind;
    assign dp_status.burst_zero = (item_reg.burst_length == 16'd0);
    assign dp_status.full = (count_reg == FULL_CNT);
    assign dp_status.empty = (count_reg == '0);

    assign done = done_reg;
    assign result = result_reg;

    assign head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    // slice arithmetic on the head entry
    assign slice_len = (rd_reg.remaining > time_quantum) ? time_quantum : rd_reg.remaining;
    assign rem_new = rd_reg.remaining - slice_len;
    assign run_new = rd_reg.run + slice_len;
    assign clock_sum = {1'b0, elapsed_reg} + {17'd0, slice_len};
    assign clock_new = clock_sum[32] ? CLOCK_MAX : clock_sum[31:0];
    assign slice_done = (rem_new == 16'd0);

    always_comb
    begin
        wr_en = 1'b0;
        wr_data = rd_reg;
        result_next = '0;
        elapsed_next = elapsed_reg;
        count_next = count_reg;
        case (cmd.op)
            OP_ADD:
            begin
                wr_en = 1'b1;
                wr_data.id = item_reg.process_id;
                wr_data.remaining = item_reg.burst_length;
                wr_data.run = 16'd0;
                count_next = count_reg + 1'b1;
                result_next.status = ST_ADDED;
            end
            OP_FULL:
                result_next.status = ST_FULL;
            OP_ZERO:
                result_next.status = ST_ZERO;
            OP_EMPTY:
                result_next.status = ST_EMPTY;
            OP_RUN:
            begin
                wr_en = !slice_done;
                wr_data.remaining = rem_new;
                wr_data.run = run_new;
                elapsed_next = clock_new;
                if (slice_done)
                    count_next = count_reg - 1'b1;
                result_next.status = ST_RUN;
                result_next.slice_owner = rd_reg.id;
                result_next.slice_length = slice_len;
                result_next.finished = slice_done;
                result_next.finish_time = clock_new;
                result_next.total_run = run_new;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[tail_reg] <= wr_data;
        if (cmd.load)
        begin
            rd_reg <= queue_mem[head_reg];
            item_reg <= item;
        end
        if (cmd.op != OP_NONE)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            elapsed_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op != OP_NONE);
            count_reg <= count_next;
            elapsed_reg <= elapsed_next;
            if (wr_en)
                tail_reg <= tail_next;
            if (cmd.op == OP_RUN)
                head_reg <= head_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with pointers apart");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (elapsed_reg >= $past(elapsed_reg)))
        else $error("elapsed clock went backward");

endmodule

/* hdl/round_robin_time_slice_scheduler.sv */
// round-robin time-slice scheduler top level: config register, controller, datapath
// depends on rrs_pkg, rrs_ctrl, rrs_datapath
// done strobes for one cycle, registered from the execute state
// beats do not overlap: the registered read of the head entry is followed by the
// update and write-back state before the next beat is taken; the receiver cannot stall
// reset: queue empty, elapsed clock zero, quantum 3; queue memory is not cleared
module round_robin_time_slice_scheduler
    import rrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_beat_t           item,
    output logic               done,
    output out_beat_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] quantum_reg;
    logic        cfg_write;
    logic        cfg_hit;
    ctrl_cmd_t   cmd;
    dp_status_t  dp_status;
    logic        ctrl_busy;

    assign pready = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_QUANTUM);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata = cfg_hit ? {16'd0, quantum_reg} : 32'd0;
    assign busy = ctrl_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quantum_reg <= QUANTUM_RESET;
        else if (cfg_write)
            quantum_reg <= pwdata[15:0];
    end

    rrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (ctrl_busy),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    rrs_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .item         (item),
        .time_quantum (quantum_reg),
        .done         (done),
        .result       (result)
    );

endmodule

/* test/round_robin_time_slice_scheduler_tb.sv */
// testbench for the round-robin time-slice scheduler: directed table and random phases
// over several quantum settings, including zero and the widest quantum
// depends on rrs_pkg and round_robin_time_slice_scheduler
module round_robin_time_slice_scheduler_tb;
    import rrs_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 270;
    localparam logic [PADDR_W-1:0] QUANTUM_ADDR = PADDR_W'(4 * int'(REG_QUANTUM));

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_beat_t           item;
    logic               done;
    out_beat_t          result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // scheduler state as predicted
    entry_t      run_queue [QUEUE_DEPTH];
    int          sched_head;
    int          sched_tail;
    int          sched_count;
    logic [31:0] sched_clock;
    logic [15:0] sched_quantum;

    out_beat_t   pending_slices [$];
    plan_row_t   plan_rows [$];
    out_beat_t   want_beat;
    int          mismatches;
    int          cycles;
    bit          steady_run;

    round_robin_time_slice_scheduler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    function automatic out_beat_t predict_slice(input in_beat_t b);
        out_beat_t   r;
        entry_t      e;
        logic [15:0] len;
        r = '0;
        if (b.kind == KIND_ADD)
        begin
            if (b.burst_length == 16'd0)
                r.status = ST_ZERO;
            else if (sched_count >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                run_queue[sched_tail] = '{b.process_id, b.burst_length, 16'd0};
                sched_tail = (sched_tail + 1) % QUEUE_DEPTH;
                sched_count++;
                r.status = ST_ADDED;
            end
        end
        else if (sched_count == 0)
            r.status = ST_EMPTY;
        else
        begin
            e = run_queue[sched_head];
            sched_head = (sched_head + 1) % QUEUE_DEPTH;
            len = (e.remaining > sched_quantum) ? sched_quantum : e.remaining;
            e.remaining = e.remaining - len;
            e.run = e.run + len;
            sched_clock = ((CLOCK_MAX - sched_clock) < {16'd0, len}) ?
                          CLOCK_MAX : sched_clock + {16'd0, len};
            if (e.remaining == 16'd0)
                sched_count--;
            else
            begin
                run_queue[sched_tail] = e;
                sched_tail = (sched_tail + 1) % QUEUE_DEPTH;
            end
            r.status = ST_RUN;
            r.slice_owner = e.id;
            r.slice_length = len;
            r.finished = (e.remaining == 16'd0);
            r.finish_time = sched_clock;
            r.total_run = e.run;
        end
        return r;
    endfunction

    function automatic in_beat_t random_beat(input int add_pct);
        in_beat_t b;
        int       pick;
        b.kind = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_DISPATCH;
        b.process_id = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 4)
            b.burst_length = 16'd0;
        else if (pick < 8)
            b.burst_length = 16'hFFFF;
        else if (pick < 22)
            b.burst_length = 16'($urandom);
        else
            b.burst_length = 16'($urandom_range(12, 1));
        return b;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic plan_row(input logic kind, input logic [7:0] pid,
                            input logic [15:0] burst, input bit typed,
                            input logic [2:0] st, input logic [7:0] owner,
                            input logic [15:0] len, input logic fin,
                            input logic [31:0] ft, input logic [15:0] run);
        plan_row_t row;
        row.beat = '{kind, pid, burst};
        row.typed = typed;
        row.want = '{st, owner, len, fin, ft, run};
        plan_rows.push_back(row);
    endtask

    task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        out_beat_t predicted;
        while (!steady_run && $urandom_range(99) < 7)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        item = b;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_slice(b);
        pending_slices.push_back(typed ? want : predicted);
    endtask

    task automatic go_quiet();
        @(negedge clk);
        start = 1'b0;
        while (pending_slices.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_quantum(input logic [15:0] q);
        go_quiet();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = QUANTUM_ADDR;
        pwdata = {16'd0, q};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sched_quantum = q;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("quantum readback", {16'd0, q}, {16'd0, prdata[15:0]});
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_slices.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: %p", result);
                mismatches++;
            end
            else
            begin
                want_beat = pending_slices.pop_front();
                check_field("status", 32'(want_beat.status), 32'(result.status));
                check_field("slice_owner", 32'(want_beat.slice_owner),
                            32'(result.slice_owner));
                check_field("slice_length", 32'(want_beat.slice_length),
                            32'(result.slice_length));
                check_field("finished", 32'(want_beat.finished), 32'(result.finished));
                check_field("finish_time", want_beat.finish_time, result.finish_time);
                check_field("total_run", 32'(want_beat.total_run), 32'(result.total_run));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, pending_slices.size());
            $display("** round_robin_time_slice_scheduler: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] quanta [6];
        int          add_pct;
        int          n_items;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        steady_run = 1'b0;
        sched_head = 0;
        sched_tail = 0;
        sched_count = 0;
        sched_clock = '0;
        sched_quantum = QUANTUM_RESET;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // quantum at its reset value
        plan_row(KIND_DISPATCH, 8'd0, 16'd0, 1, ST_EMPTY, 8'd0, 16'd0, 0, 32'd0, 16'd0);
        plan_row(KIND_ADD, 8'hA5, 16'd0, 1, ST_ZERO, 8'd0, 16'd0, 0, 32'd0, 16'd0);
        plan_row(KIND_ADD, 8'hFF, 16'hFFFF, 1, ST_ADDED, 8'd0, 16'd0, 0, 32'd0, 16'd0);
        plan_row(KIND_ADD, 8'h00, 16'd1, 1, ST_ADDED, 8'd0, 16'd0, 0, 32'd0, 16'd0);
        plan_row(KIND_DISPATCH, 8'd0, 16'd0, 1, ST_RUN, 8'hFF, 16'd3, 0, 32'd3, 16'd3);
        plan_row(KIND_DISPATCH, 8'd0, 16'd0, 1, ST_RUN, 8'h00, 16'd1, 1, 32'd4, 16'd1);
        for (int i = 1; i < QUEUE_DEPTH; i++)
            plan_row(KIND_ADD, 8'(i), 16'(i), 1, ST_ADDED, 8'd0, 16'd0, 0, 32'd0, 16'd0);
        plan_row(KIND_ADD, 8'h5A, 16'd9, 1, ST_FULL, 8'd0, 16'd0, 0, 32'd0, 16'd0);
        plan_row(KIND_DISPATCH, 8'd0, 16'd0, 1, ST_RUN, 8'hFF, 16'd3, 0, 32'd7, 16'd6);
        plan_row(KIND_DISPATCH, 8'd0, 16'd0, 1, ST_RUN, 8'h01, 16'd1, 1, 32'd8, 16'd1);
        plan_row(KIND_DISPATCH, 8'd0, 16'd0, 0, ST_RUN, 8'd0, 16'd0, 0, 32'd0, 16'd0);

        foreach (plan_rows[i])
            send_beat(plan_rows[i].beat, plan_rows[i].typed, plan_rows[i].want);

        quanta[0] = 16'd1;
        quanta[1] = 16'hFFFF;
        quanta[2] = 16'd0;
        quanta[3] = 16'($urandom_range(8, 2));
        quanta[4] = 16'($urandom_range(65535, 1));
        quanta[5] = QUANTUM_RESET;

        foreach (quanta[p])
        begin
            write_quantum(quanta[p]);
            n_items = (quanta[p] == 16'd0) ? 100 : PHASE_ITEMS;
            add_pct = 50;
            for (int i = 0; i < n_items; i++)
            begin
                // shift the add mix so the queue swings between full and empty
                if (i % 40 == 0)
                    add_pct = 25 + 25 * $urandom_range(2);
                steady_run = (p == 1 && i >= 50 && i < 200);
                if (i % 200 == 199)
                    go_quiet();
                send_beat(random_beat(add_pct), 0, '0);
            end
        end
        steady_run = 1'b0;

        go_quiet();
        repeat (4)
            @(posedge clk);
        if (mismatches == 0)
            $display("** round_robin_time_slice_scheduler: PASSED **");
        else
            $display("** round_robin_time_slice_scheduler: FAILED **");
        $finish;
    end
endmodule

/* sim.f */
hdl/rrs_pkg.sv
hdl/rrs_ctrl.sv
hdl/rrs_datapath.sv
hdl/round_robin_time_slice_scheduler.sv
test/round_robin_time_slice_scheduler_tb.sv
